FILE: design/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// shared types and constants of the periodic sample scheduler
// ----------------------------------------------------------------------------
package pss_pkg;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_ADD   = 2'd2
    } t_op;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_DUE    = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [31:0] addr;
        logic [3:0]  rate;
        logic [15:0] ticks;
    } t_entry;

    typedef struct packed {
        logic clear;
        logic add_write;
        logic add_full;
        logic scan_start;
        logic scan_step;
        logic flush_push;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic fire;
        logic pend_valid;
        logic scan_last;
        logic count_zero;
        logic count_full;
    } t_status;

    function automatic logic [15:0] rate_interval(input logic [3:0] code);
        logic [15:0] v;
        unique case (code)
            4'd1:    v = 16'd1;
            4'd2:    v = 16'd5;
            4'd3:    v = 16'd10;
            4'd4:    v = 16'd20;
            4'd5:    v = 16'd50;
            4'd6:    v = 16'd100;
            4'd7:    v = 16'd200;
            4'd8:    v = 16'd500;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: design/periodic_sample_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_sample_scheduler
// table of watched addresses with per-entry tick counters and due reporting
// ----------------------------------------------------------------------------
// A clear or a tick on an empty table completes in the idle state; an add passes
// through the add state until the output word is free. A tick walks the live
// entries through the single table memory, one entry a cycle, and a due word
// that finds the output register still occupied holds the walk until that
// register frees. Due words leave one entry behind the walk, so tlast can
// mark the final one. The next input word is taken once the walk is over and
// the final due word has moved into the output register, even while that
// word still waits there.
module periodic_sample_scheduler
    import pss_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
)(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // watch_address [31:0], rate_code [35:32], zero [39:36]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // op [1:0]
    input  logic [1:0]             i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // status [0], slot [4:1], due_address [36:5], zero [39:37]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // kind [0]
    output logic                   o_m_axis_tuser,
    output logic                   o_m_axis_tlast
);

    t_cmd        cmd;
    t_status     status;
    logic        out_status;
    logic [3:0]  slot;
    logic [31:0] due_address;

    pss_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_op     (i_s_axis_tuser),
        .i_status (status),
        .o_ready  (o_s_axis_tready),
        .o_cmd    (cmd)
    );

    pss_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_accept     (i_s_axis_tvalid && o_s_axis_tready),
        .i_watch_address (i_s_axis_tdata[31:0]),
        .i_rate_code     (i_s_axis_tdata[35:32]),
        .i_cmd           (cmd),
        .i_out_ready     (i_m_axis_tready),
        .o_status        (status),
        .o_out_valid     (o_m_axis_tvalid),
        .o_kind          (o_m_axis_tuser),
        .o_out_status    (out_status),
        .o_slot          (slot),
        .o_due_address   (due_address),
        .o_last          (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {3'b000, due_address, slot, out_status};

endmodule

FILE: design/pss_ctrl.sv
// ----------------------------------------------------------------------------
// pss_ctrl
// sequencer for add, clear and the tick walk over the table
// ----------------------------------------------------------------------------
module pss_ctrl
    import pss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_op,
    input  t_status    i_status,
    output logic       o_ready,
    output t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ADD   = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_FLUSH = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    priority if (i_op == OP_CLEAR) begin
                        o_cmd.clear = 1'b1;
                    end else if (i_op == OP_ADD) begin
                        n_state = ST_ADD;
                    end else if (i_op == OP_TICK && !i_status.count_zero) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = ST_SCAN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_ADD: begin
                if (i_status.out_free) begin
                    o_cmd.add_full  = i_status.count_full;
                    o_cmd.add_write = !i_status.count_full;
                    n_state         = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (i_status.out_free || !i_status.fire || !i_status.pend_valid) begin
                    o_cmd.scan_step = 1'b1;
                    if (i_status.scan_last) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!i_status.pend_valid) begin
                    n_state = ST_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.flush_push = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: design/pss_datapath.sv
// ----------------------------------------------------------------------------
// pss_datapath
// entry table memory, entry count, tick update, pending and output words
// ----------------------------------------------------------------------------
module pss_datapath
    import pss_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_accept,
    input  logic [31:0] i_watch_address,
    input  logic [3:0]  i_rate_code,
    input  t_cmd        i_cmd,
    input  logic        i_out_ready,
    output t_status     o_status,
    output logic        o_out_valid,
    output logic        o_kind,
    output logic        o_out_status,
    output logic [3:0]  o_slot,
    output logic [31:0] o_due_address,
    output logic        o_last
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    t_entry          r_mem [TABLE_ENTRIES];
    t_entry          r_rd;
    logic [CW-1:0]   r_count;
    logic [IW-1:0]   r_idx;
    logic [IW-1:0]   rd_addr;
    logic [31:0]     r_in_addr;
    logic [3:0]      r_in_rate;
    logic            r_pend_valid;
    logic [IW-1:0]   r_pend_slot;
    logic [31:0]     r_pend_addr;
    logic            r_out_valid;
    logic            r_out_kind;
    logic            r_out_status;
    logic [3:0]      r_out_slot;
    logic [31:0]     r_out_addr;
    logic            r_out_last;

    logic [15:0]     interval;
    logic [15:0]     ticks_inc;
    logic            fire;
    logic            scan_last;
    logic            push_pend;

    assign interval  = rate_interval(r_rd.rate);
    assign ticks_inc = r_rd.ticks + 16'd1;
    assign fire      = (interval != 16'd0) && (ticks_inc >= interval);
    assign scan_last = ((CW'(r_idx) + CW'(1)) == r_count);
    assign push_pend = i_cmd.scan_step && fire && r_pend_valid;

    always_comb begin
        priority if (i_cmd.scan_start) begin
            rd_addr = '0;
        end else if (i_cmd.scan_step && !scan_last) begin
            rd_addr = r_idx + IW'(1);
        end else begin
            rd_addr = r_idx;
        end
    end

    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_status.fire       = fire;
    assign o_status.pend_valid = r_pend_valid;
    assign o_status.scan_last  = scan_last;
    assign o_status.count_zero = (r_count == '0);
    assign o_status.count_full = (r_count >= CW'(TABLE_ENTRIES));

    // table memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_write) begin
            r_mem[IW'(r_count)] <= '{addr: r_in_addr, rate: r_in_rate, ticks: 16'd0};
        end else if (i_cmd.scan_step) begin
            r_mem[r_idx] <= '{addr: r_rd.addr, rate: r_rd.rate,
                              ticks: (fire ? 16'd0 : ticks_inc)};
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_in_addr <= i_watch_address;
            r_in_rate <= i_rate_code;
        end
        if (i_cmd.scan_step && fire) begin
            r_pend_slot <= r_idx;
            r_pend_addr <= r_rd.addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (i_cmd.clear || i_cmd.add_full) begin
                r_count <= '0;
            end else if (i_cmd.add_write) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.scan_start) begin
                r_idx        <= '0;
                r_pend_valid <= 1'b0;
            end else if (i_cmd.scan_step) begin
                if (!scan_last) begin
                    r_idx <= r_idx + IW'(1);
                end
                if (fire) begin
                    r_pend_valid <= 1'b1;
                end
            end else if (i_cmd.flush_push) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.add_write || i_cmd.add_full || push_pend || i_cmd.flush_push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_write) begin
            r_out_kind   <= KIND_STATUS;
            r_out_status <= STATUS_OK;
            r_out_slot   <= 4'(r_count);
            r_out_addr   <= 32'd0;
            r_out_last   <= 1'b1;
        end else if (i_cmd.add_full) begin
            r_out_kind   <= KIND_STATUS;
            r_out_status <= STATUS_FULL;
            r_out_slot   <= 4'd0;
            r_out_addr   <= 32'd0;
            r_out_last   <= 1'b1;
        end else if (push_pend || i_cmd.flush_push) begin
            r_out_kind   <= KIND_DUE;
            r_out_status <= STATUS_OK;
            r_out_slot   <= 4'(r_pend_slot);
            r_out_addr   <= r_pend_addr;
            r_out_last   <= i_cmd.flush_push;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_out_status  = r_out_status;
    assign o_slot        = r_out_slot;
    assign o_due_address = r_out_addr;
    assign o_last        = r_out_last;

endmodule

FILE: design/pss_checker.sv
// ----------------------------------------------------------------------------
// pss_checker
// port-level checks of the periodic sample scheduler, bound to the top level
// ----------------------------------------------------------------------------
module pss_checker
    import pss_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_out_tvalid,
    input  logic                   i_out_tready,
    input  logic [OUT_TDATA_W-1:0] i_out_tdata,
    input  logic                   i_out_tuser,
    input  logic                   i_out_tlast
);

    // stalled word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_tvalid && !i_out_tready |=> i_out_tvalid)
        else $error("output word dropped while stalled");

    // an add answer is always the only word of its input
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_tvalid && (i_out_tuser == KIND_STATUS) |-> i_out_tlast)
        else $error("add status without tlast");

    // due words never carry a full status
    a_due_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_tvalid && (i_out_tuser == KIND_DUE) |-> (i_out_tdata[0] == STATUS_OK))
        else $error("due word with nonzero status");

    // table full answer has slot and address zero
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_tvalid && (i_out_tuser == KIND_STATUS) && (i_out_tdata[0] == STATUS_FULL)
        |-> (i_out_tdata[36:1] == 36'd0))
        else $error("table full word with nonzero slot or address");

endmodule

bind periodic_sample_scheduler pss_checker u_pss_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_tvalid (o_m_axis_tvalid),
    .i_out_tready (i_m_axis_tready),
    .i_out_tdata  (o_m_axis_tdata),
    .i_out_tuser  (o_m_axis_tuser),
    .i_out_tlast  (o_m_axis_tlast)
);

FILE: sim/tb_periodic_sample_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_sample_scheduler
// self-checking testbench of the periodic sample scheduler
// ----------------------------------------------------------------------------
// Words sent on the input stream are fed at acceptance into a local copy of
// the watch table, which predicts the add status and sample-due words. The
// output stream is compared field by field against the queue of predicted
// words. Directed tests cover the empty table, clears, extreme addresses,
// every rate code, table overflow and the slowest rates. A long receiver
// hold fills the block up. A random phase of add and tick sequences, with
// some noise, follows. Both sides idle at random, except in a calm stretch.
// ----------------------------------------------------------------------------
module tb_periodic_sample_scheduler;
    import pss_pkg::*;

    localparam int          N_SLOTS     = 16;
    localparam logic [1:0]  OP_RESERVED = 2'd3;
    localparam int          HOLD_CYCLES = 400;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          DRAIN_WAIT  = 64;
    localparam int          RANDOM_ITEMS = 85;
    localparam int          SLOW_TICKS  = 205;

    typedef struct packed {
        logic        kind;
        logic        status;
        logic [3:0]  slot;
        logic [31:0] addr;
        logic        last;
    } t_out_word;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    // watch_address [31:0], rate_code [35:32], zero [39:36]
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    // op [1:0]
    logic [1:0]             i_s_axis_tuser;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    // status [0], slot [4:1], due_address [36:5], zero [39:37]
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    // kind [0]
    logic                   o_m_axis_tuser;
    logic                   o_m_axis_tlast;

    logic [31:0] watch_addr [N_SLOTS];
    logic [3:0]  watch_rate [N_SLOTS];
    logic [15:0] watch_ticks [N_SLOTS];
    int          watch_count;

    t_out_word   pending_words [$];
    int          mismatches;
    int          cycle_count = 0;
    logic        calm;
    logic        hold_req;
    int          hold_left = 0;

    periodic_sample_scheduler #(
        .TABLE_ENTRIES(N_SLOTS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [15:0] ticks_per_sample(input logic [3:0] code);
        logic [15:0] n;
        unique case (code)
            4'd1:    n = 16'd1;
            4'd2:    n = 16'd5;
            4'd3:    n = 16'd10;
            4'd4:    n = 16'd20;
            4'd5:    n = 16'd50;
            4'd6:    n = 16'd100;
            4'd7:    n = 16'd200;
            4'd8:    n = 16'd500;
            default: n = 16'd0;
        endcase
        return n;
    endfunction

    function automatic void wipe_watch_table();
        watch_count = 0;
        for (int i = 0; i < N_SLOTS; i++) begin
            watch_addr[i]  = '0;
            watch_rate[i]  = '0;
            watch_ticks[i] = '0;
        end
    endfunction

    function automatic void advance_watch_table(input logic [1:0] op,
                                                input logic [31:0] addr,
                                                input logic [3:0] rate);
        t_out_word   w;
        logic [15:0] iv;
        logic [15:0] due_mask;
        int          last_due;
        due_mask = '0;
        last_due = -1;
        if (op == OP_CLEAR) begin
            wipe_watch_table();
        end else if (op == OP_ADD) begin
            if (watch_count >= N_SLOTS) begin
                wipe_watch_table();
                w = '{kind: KIND_STATUS, status: STATUS_FULL, slot: 4'd0,
                      addr: 32'd0, last: 1'b1};
            end else begin
                watch_addr[watch_count]  = addr;
                watch_rate[watch_count]  = rate;
                watch_ticks[watch_count] = '0;
                w = '{kind: KIND_STATUS, status: STATUS_OK,
                      slot: watch_count[3:0], addr: 32'd0, last: 1'b1};
                watch_count++;
            end
            pending_words.push_back(w);
        end else if (op == OP_TICK && watch_count != 0) begin
            for (int i = 0; i < watch_count; i++) begin
                iv = ticks_per_sample(watch_rate[i]);
                watch_ticks[i] = watch_ticks[i] + 16'd1;
                if (iv != 0 && watch_ticks[i] >= iv) begin
                    watch_ticks[i] = '0;
                    due_mask[i] = 1'b1;
                    last_due = i;
                end
            end
            for (int i = 0; i < N_SLOTS; i++) begin
                if (due_mask[i]) begin
                    w = '{kind: KIND_DUE, status: STATUS_OK, slot: i[3:0],
                          addr: watch_addr[i], last: (i == last_due)};
                    pending_words.push_back(w);
                end
            end
        end
    endfunction

    // input side: one word per call, held until accepted
    task automatic send_word(input logic [1:0] op, input logic [31:0] addr,
                             input logic [3:0] rate);
        if (!calm) begin
            while ($urandom_range(0, 99) < 24) begin
                i_s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {4'd0, rate, addr};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        advance_watch_table(op, addr, rate);
    endtask

    task automatic send_tick();
        send_word(OP_TICK, $urandom, 4'($urandom));
    endtask

    task automatic send_add(input logic [31:0] addr, input logic [3:0] rate);
        send_word(OP_ADD, addr, rate);
    endtask

    // output side
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
        if (hold_req || hold_left > 1) begin
            i_m_axis_tready <= 1'b0;
        end else if (calm) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= 24);
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        t_out_word got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = '{kind: o_m_axis_tuser, status: o_m_axis_tdata[0],
                    slot: o_m_axis_tdata[4:1], addr: o_m_axis_tdata[36:5],
                    last: o_m_axis_tlast};
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: kind %0d status %0d slot %0d addr %h last %0d",
                             got.kind, got.status, got.slot, got.addr, got.last);
            end else begin
                want = pending_words.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected kind %0d status %0d slot %0d addr %h last %0d",
                                 want.kind, want.status, want.slot, want.addr, want.last);
                        $display("          got kind %0d status %0d slot %0d addr %h last %0d",
                                 got.kind, got.status, got.slot, got.addr, got.last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_periodic_sample_scheduler failed");
            $finish;
        end
    end

    task automatic test_empty_and_clear();
        send_tick();
        send_word(OP_CLEAR, 32'hFFFF_FFFF, 4'hF);
        send_word(OP_RESERVED, 32'hFFFF_FFFF, 4'hF);
        send_tick();
    endtask

    task automatic test_add_extremes();
        send_add(32'h0000_0000, 4'd1);
        send_add(32'hFFFF_FFFF, 4'd8);
        send_add(32'hA5A5_5A5A, 4'd0);
        send_add(32'h5A5A_A5A5, 4'd15);
        send_tick();
        send_tick();
        send_word(OP_RESERVED, 32'h1234_5678, 4'd2);
        send_tick();
        send_word(OP_CLEAR, 32'h0, 4'd0);
        send_tick();
    endtask

    task automatic test_table_full();
        for (int i = 0; i < N_SLOTS; i++)
            send_add({8'hC0, 8'(i), 16'($urandom)}, 4'(i));
        send_tick();
        send_add(32'hDEAD_BEEF, 4'd1);
        send_tick();
        send_add(32'h8000_0001, 4'd1);
        send_tick();
    endtask

    task automatic test_slow_rates();
        send_word(OP_CLEAR, 32'h0, 4'd0);
        for (int r = 0; r < N_SLOTS; r++)
            send_add($urandom, 4'(r));
        for (int t = 0; t < SLOW_TICKS; t++)
            send_tick();
    endtask

    task automatic test_backpressure();
        send_word(OP_CLEAR, 32'h0, 4'd0);
        for (int i = 0; i < N_SLOTS; i++)
            send_add($urandom, 4'd1);
        i_s_axis_tvalid <= 1'b0;
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        for (int t = 0; t < 8; t++)
            send_tick();
    endtask

    task automatic test_random();
        int sent;
        int n_add;
        int n_tick;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            calm <= (sent >= 20 && sent < 70);
            if ($urandom_range(0, 99) < 85) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_word(OP_CLEAR, $urandom, 4'($urandom));
                    sent++;
                end
                n_add = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 18)
                                                    : $urandom_range(1, 6);
                for (int i = 0; i < n_add; i++) begin
                    send_add($urandom, ($urandom_range(0, 9) < 8)
                             ? 4'($urandom_range(1, 4)) : 4'($urandom));
                    sent++;
                end
                n_tick = $urandom_range(3, 25);
                for (int i = 0; i < n_tick; i++) begin
                    send_tick();
                    sent++;
                end
            end else begin
                send_word(2'($urandom), $urandom, 4'($urandom));
                sent++;
            end
        end
        calm <= 1'b0;
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= OP_TICK;
        i_m_axis_tready <= 1'b0;
        calm            <= 1'b0;
        hold_req        <= 1'b0;
        mismatches      = 0;
        wipe_watch_table();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_clear();
        test_add_extremes();
        test_table_full();
        test_slow_rates();
        test_backpressure();
        test_random();

        i_s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (pending_words.size() != 0)
            mismatches++;
        if (mismatches == 0) begin
            $display("tb_periodic_sample_scheduler passed");
        end else begin
            $display("tb_periodic_sample_scheduler failed");
        end
        $finish;
    end

endmodule
